>>> rtl/core/bcs_pkg.sv
// bcs_pkg: shared types, constants and codes of the blended character cell store
// used by the top, bcs_cfg and bcs_blend, no dependencies of its own

package bcs_pkg;

  // default size of the cell store
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 64;

  // field widths
  localparam int GLYPH_W    = 21;
  localparam int COLOR_W    = 32;
  localparam int COORD_W    = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 88;

  // special code points
  localparam logic [GLYPH_W-1:0] GLYPH_KEEP  = 21'd1;
  localparam logic [GLYPH_W-1:0] GLYPH_CONT  = 21'd8;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 21'd32;

  // register reset values
  localparam logic [8:0]  RST_WIDTH  = 9'd256;
  localparam logic [6:0]  RST_HEIGHT = 7'd64;
  localparam logic [15:0] RST_LEFT   = 16'd0;
  localparam logic [15:0] RST_TOP    = 16'd0;
  localparam logic [15:0] RST_RIGHT  = 16'd255;
  localparam logic [15:0] RST_BOTTOM = 16'd63;

  // operation codes carried in in_tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  // result status carried in out_tuser
  typedef enum logic [1:0] {
    STATUS_WRITTEN = 2'd0,
    STATUS_CLIPPED = 2'd1,
    STATUS_READ_OK = 2'd2,
    STATUS_OOR     = 2'd3
  } status_t;

  // register indexes, byte address 4*index
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_LEFT   = 3'd2,
    REG_TOP    = 3'd3,
    REG_RIGHT  = 3'd4,
    REG_BOTTOM = 3'd5
  } reg_idx_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [8:0]         buffer_width;
    logic [6:0]         buffer_height;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic signed [15:0] clip_right;
    logic signed [15:0] clip_bottom;
  } cfg_t;

endpackage

>>> rtl/core/blended_character_cell_store_top.sv
// blended_character_cell_store_top: character cell store with alpha-blended writes
// depends on bcs_pkg, bcs_ram, bcs_cfg, bcs_blend
//
// Usage. Words enter on the in_ stream: in_tuser holds the opcode (write or read),
// in_tdata the cell address and the glyph and colors to blend. Each word makes one
// result word on the out_ stream: out_tuser holds the status, out_tdata the cell
// after the operation (all zero for a clipped write or an out-of-range read).
// The cfg_ apb port sets buffer size and clip window; write it only while idle.
// Items are handled one at a time around a read-modify-write of the glyph ram and
// the color ram, whose reads are registered. A clipped or out-of-range word goes
// straight to the hold state; a read passes through evaluation, a write through
// evaluation and mix, with the leftward clearing walk between them when the
// target holds a continuation mark (one glyph ram read and one write per cell).
// out_tvalid comes from the output register, loaded from the hold state; the next
// word is accepted while a result waits in the output register, and a stalled
// receiver holds the block only once a second result is ready. After reset a
// clearing pass zeroes both rams, in_tready low; config writes are taken meanwhile.

module blended_character_cell_store_top #(
  parameter int MAX_COLS = bcs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bcs_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input words
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata from bit 0: col, row, glyph, fore_alpha, fore_red, fore_green,
  // fore_blue, back_alpha, back_red, back_green, back_blue, zero pad
  input  logic [bcs_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: opcode
  input  logic [0:0]                     in_tuser,
  // result words
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata from bit 0: cell_glyph, cell_fore_alpha, cell_fore_red,
  // cell_fore_green, cell_fore_blue, cell_back_alpha, cell_back_red,
  // cell_back_green, cell_back_blue, zero pad
  output logic [bcs_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: status
  output logic [1:0]                     out_tuser,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WCNT_W = $clog2(MAX_COLS + 1);
  localparam int HCNT_W = $clog2(MAX_ROWS + 1);
  localparam int PROD_W = ROW_W + WCNT_W;
  localparam int GW     = bcs_pkg::GLYPH_W;
  localparam int CW     = bcs_pkg::COLOR_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_MIX,
    ST_HOLD
  } state_t;

  state_t           state_r;
  bcs_pkg::cfg_t    cfg;

  // input fields
  logic signed [15:0] x_in;
  logic signed [15:0] y_in;
  logic [GW-1:0]      glyph_in;
  logic [CW-1:0]      fore_in;
  logic [CW-1:0]      back_in;
  logic               op_read_in;

  // address decode
  logic [WCNT_W-1:0]  w_eff;
  logic [HCNT_W-1:0]  h_eff;
  logic               in_range;
  logic               clipped;
  logic [PROD_W-1:0]  idx_full;
  logic [ADDR_W-1:0]  idx_in;
  logic               accept;

  // item registers
  logic               op_read_r;
  logic [ADDR_W-1:0]  idx_r;
  logic [COL_W-1:0]   col_r;
  logic [GW-1:0]      glyph_r;
  logic [CW-1:0]      fore_new_r;
  logic [CW-1:0]      back_new_r;
  logic [GW-1:0]      old_glyph_r;
  logic [ADDR_W-1:0]  walk_addr_r;
  logic [COL_W-1:0]   walk_col_r;
  logic [ADDR_W-1:0]  clr_addr_r;

  // pending and output result
  bcs_pkg::status_t   pend_status_r;
  logic [GW-1:0]      pend_glyph_r;
  logic [CW-1:0]      pend_fore_r;
  logic [CW-1:0]      pend_back_r;
  logic               out_valid_r;
  bcs_pkg::status_t   out_status_r;
  logic [GW-1:0]      out_glyph_r;
  logic [CW-1:0]      out_fore_r;
  logic [CW-1:0]      out_back_r;

  // ram ports
  logic               g_we;
  logic [ADDR_W-1:0]  g_waddr;
  logic [GW-1:0]      g_wdata;
  logic               g_re;
  logic [ADDR_W-1:0]  g_raddr;
  logic [GW-1:0]      g_rdata;
  logic               c_we;
  logic [ADDR_W-1:0]  c_waddr;
  logic [2*CW-1:0]    c_wdata;
  logic [2*CW-1:0]    c_rdata;

  // blend units
  logic               blend_load;
  logic [CW-1:0]      fore_mix;
  logic [CW-1:0]      back_mix;
  logic [GW-1:0]      new_glyph;
  logic               out_load;

  // configuration registers
  bcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // unpack the input word, colors as {a, r, g, b}
  assign x_in       = in_tdata[15:0];
  assign y_in       = in_tdata[31:16];
  assign glyph_in   = in_tdata[52:32];
  assign fore_in    = {in_tdata[60:53], in_tdata[68:61], in_tdata[76:69], in_tdata[84:77]};
  assign back_in    = {in_tdata[92:85], in_tdata[100:93], in_tdata[108:101],
                       in_tdata[116:109]};
  assign op_read_in = (in_tuser[0] == bcs_pkg::OP_READ);

  // buffer size limited to the store size
  assign w_eff = (32'(cfg.buffer_width) > 32'(MAX_COLS)) ? WCNT_W'(MAX_COLS)
                                                          : WCNT_W'(cfg.buffer_width);
  assign h_eff = (32'(cfg.buffer_height) > 32'(MAX_ROWS)) ? HCNT_W'(MAX_ROWS)
                                                           : HCNT_W'(cfg.buffer_height);

  // range and clip checks, cell index row*w+col
  assign in_range = !x_in[15] && !y_in[15] &&
                    (32'($unsigned(x_in)) < 32'(w_eff)) &&
                    (32'($unsigned(y_in)) < 32'(h_eff));
  assign clipped  = (x_in < cfg.clip_left) || (x_in > cfg.clip_right) ||
                    (y_in < cfg.clip_top) || (y_in > cfg.clip_bottom);
  assign idx_full = PROD_W'(y_in[ROW_W-1:0]) * PROD_W'(w_eff) + PROD_W'(x_in[COL_W-1:0]);
  assign idx_in   = ADDR_W'(idx_full);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_HOLD) && (!out_valid_r || out_tready);

  // blend loads from the ram read data during evaluation of a write
  assign blend_load = (state_r == ST_EVAL) && !op_read_r;
  assign new_glyph  = (glyph_r == bcs_pkg::GLYPH_KEEP) ? old_glyph_r : glyph_r;

  bcs_blend u_fore_blend (
    .clk   (clk),
    .load  (blend_load),
    .old_c (c_rdata[2*CW-1:CW]),
    .new_c (fore_new_r),
    .mix_c (fore_mix)
  );

  bcs_blend u_back_blend (
    .clk   (clk),
    .load  (blend_load),
    .old_c (c_rdata[CW-1:0]),
    .new_c (back_new_r),
    .mix_c (back_mix)
  );

  // ram port selection
  always_comb begin
    g_we    = 1'b0;
    g_waddr = idx_r;
    g_wdata = new_glyph;
    c_we    = 1'b0;
    c_waddr = idx_r;
    c_wdata = {fore_mix, back_mix};
    unique case (state_r)
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr_r;
        g_wdata = '0;
        c_we    = 1'b1;
        c_waddr = clr_addr_r;
        c_wdata = '0;
      end
      ST_WALK_WR: begin
        g_we    = 1'b1;
        g_waddr = walk_addr_r;
        g_wdata = bcs_pkg::GLYPH_SPACE;
      end
      ST_MIX: begin
        g_we = 1'b1;
        c_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign g_re    = accept || (state_r == ST_WALK_RD);
  assign g_raddr = (state_r == ST_WALK_RD) ? walk_addr_r : idx_in;

  bcs_ram #(
    .WIDTH (GW),
    .DEPTH (CELLS)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // fore color in the upper half, back color in the lower half
  bcs_ram #(
    .WIDTH (2 * CW),
    .DEPTH (CELLS)
  ) u_color_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (accept),
    .raddr (idx_in),
    .rdata (c_rdata)
  );

  // sequencer with result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= pend_status_r;
        out_glyph_r  <= pend_glyph_r;
        out_fore_r   <= pend_fore_r;
        out_back_r   <= pend_back_r;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end

      unique case (state_r)
        // zero every cell once after reset
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        // take a word, drop clipped or out-of-range ones at once
        ST_IDLE: begin
          if (accept) begin
            op_read_r  <= op_read_in;
            idx_r      <= idx_in;
            col_r      <= x_in[COL_W-1:0];
            glyph_r    <= glyph_in;
            fore_new_r <= fore_in;
            back_new_r <= back_in;
            pend_glyph_r <= '0;
            pend_fore_r  <= '0;
            pend_back_r  <= '0;
            if (op_read_in && !in_range) begin
              pend_status_r <= bcs_pkg::STATUS_OOR;
              state_r       <= ST_HOLD;
            end else if (!op_read_in && (!in_range || clipped)) begin
              pend_status_r <= bcs_pkg::STATUS_CLIPPED;
              state_r       <= ST_HOLD;
            end else begin
              state_r <= ST_EVAL;
            end
          end
        end
        // ram data of the addressed cell is here
        ST_EVAL: begin
          if (op_read_r) begin
            pend_status_r <= bcs_pkg::STATUS_READ_OK;
            pend_glyph_r  <= g_rdata;
            pend_fore_r   <= c_rdata[2*CW-1:CW];
            pend_back_r   <= c_rdata[CW-1:0];
            state_r       <= ST_HOLD;
          end else if (g_rdata == bcs_pkg::GLYPH_CONT) begin
            // the walk starts at the target, so a kept glyph there becomes a space
            old_glyph_r <= bcs_pkg::GLYPH_SPACE;
            walk_addr_r <= idx_r;
            walk_col_r  <= col_r;
            state_r     <= ST_WALK_RD;
          end else begin
            old_glyph_r <= g_rdata;
            state_r     <= ST_MIX;
          end
        end
        ST_WALK_RD: begin
          state_r <= ST_WALK_WR;
        end
        // clear this cell, stop after the head or at column zero
        ST_WALK_WR: begin
          if ((g_rdata != bcs_pkg::GLYPH_CONT) || (walk_col_r == '0)) begin
            state_r <= ST_MIX;
          end else begin
            walk_addr_r <= walk_addr_r - 1'b1;
            walk_col_r  <= walk_col_r - 1'b1;
            state_r     <= ST_WALK_RD;
          end
        end
        // write back glyph and blended colors
        ST_MIX: begin
          pend_status_r <= bcs_pkg::STATUS_WRITTEN;
          pend_glyph_r  <= new_glyph;
          pend_fore_r   <= fore_mix;
          pend_back_r   <= back_mix;
          state_r       <= ST_HOLD;
        end
        // wait for the output register to free up
        ST_HOLD: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // pack the result word, colors as alpha, red, green, blue from the low bits
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'd0,
                       out_back_r[7:0], out_back_r[15:8], out_back_r[23:16],
                       out_back_r[31:24],
                       out_fore_r[7:0], out_fore_r[15:8], out_fore_r[23:16],
                       out_fore_r[31:24],
                       out_glyph_r};

  // one item at a time: no second word right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("word accepted while an item is in flight");

  // the rams are not written while waiting for input
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!g_we && !c_we))
    else $error("ram write while idle");

  // a stalled output keeps the pending result parked
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_HOLD) && out_valid_r && !out_tready) |=>
      ((state_r == ST_HOLD) && out_valid_r))
    else $error("pending result lost under stall");

  // the clearing walk never leaves the row of the target
  a_walk_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK_WR) |-> (32'(idx_r) - 32'(walk_addr_r) == 32'(col_r - walk_col_r)))
    else $error("walk address off the target row");

endmodule

>>> rtl/core/bcs_ram.sv
// bcs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module bcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bcs_cfg.sv
// bcs_cfg: apb-style configuration registers of the cell store
// depends on bcs_pkg

module bcs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bcs_pkg::CFG_DATA_W-1:0] prdata,
  output bcs_pkg::cfg_t                  cfg
);

  bcs_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_width  <= bcs_pkg::RST_WIDTH;
      cfg_r.buffer_height <= bcs_pkg::RST_HEIGHT;
      cfg_r.clip_left     <= bcs_pkg::RST_LEFT;
      cfg_r.clip_top      <= bcs_pkg::RST_TOP;
      cfg_r.clip_right    <= bcs_pkg::RST_RIGHT;
      cfg_r.clip_bottom   <= bcs_pkg::RST_BOTTOM;
    end else if (wr_en) begin
      unique case (reg_idx)
        bcs_pkg::REG_WIDTH:  cfg_r.buffer_width  <= pwdata[8:0];
        bcs_pkg::REG_HEIGHT: cfg_r.buffer_height <= pwdata[6:0];
        bcs_pkg::REG_LEFT:   cfg_r.clip_left     <= pwdata[15:0];
        bcs_pkg::REG_TOP:    cfg_r.clip_top      <= pwdata[15:0];
        bcs_pkg::REG_RIGHT:  cfg_r.clip_right    <= pwdata[15:0];
        bcs_pkg::REG_BOTTOM: cfg_r.clip_bottom   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      bcs_pkg::REG_WIDTH:  prdata = {23'd0, cfg_r.buffer_width};
      bcs_pkg::REG_HEIGHT: prdata = {25'd0, cfg_r.buffer_height};
      bcs_pkg::REG_LEFT:   prdata = {16'd0, cfg_r.clip_left};
      bcs_pkg::REG_TOP:    prdata = {16'd0, cfg_r.clip_top};
      bcs_pkg::REG_RIGHT:  prdata = {16'd0, cfg_r.clip_right};
      bcs_pkg::REG_BOTTOM: prdata = {16'd0, cfg_r.clip_bottom};
      default:             prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/bcs_blend.sv
// bcs_blend: two-step alpha blend of a new argb color over an old one
// products registered on load, divide by 255 and selection after; uses bcs_pkg

module bcs_blend (
  input  logic                        clk,
  input  logic                        load,
  input  logic [bcs_pkg::COLOR_W-1:0] old_c,
  input  logic [bcs_pkg::COLOR_W-1:0] new_c,
  output logic [bcs_pkg::COLOR_W-1:0] mix_c
);

  logic [7:0]                  alpha_new;
  logic [7:0]                  inv;
  logic [8:0]                  alpha_sum;
  logic [15:0]                 acc_nxt [3];
  logic [15:0]                 acc_r   [3];
  logic [15:0]                 rnd     [3];
  logic [7:0]                  alpha_r;
  logic                        old_zero_r;
  logic                        new_zero_r;
  logic [bcs_pkg::COLOR_W-1:0] old_r;
  logic [bcs_pkg::COLOR_W-1:0] new_r;
  logic [bcs_pkg::COLOR_W-1:0] mixed;

  assign alpha_new = new_c[31:24];
  assign inv       = 8'd255 - alpha_new;
  assign alpha_sum = {1'b0, old_c[31:24]} + {1'b0, alpha_new};

  // weighted sums per color channel, at most 255*255
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = ({8'd0, old_c[8*i +: 8]} * {8'd0, inv}) +
                   ({8'd0, new_c[8*i +: 8]} * {8'd0, alpha_new});
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
      alpha_r    <= alpha_sum[8] ? 8'd255 : alpha_sum[7:0];
      old_zero_r <= (old_c == '0);
      new_zero_r <= (new_c == '0);
      old_r      <= old_c;
      new_r      <= new_c;
    end
  end

  // floor divide by 255: (v + 1 + (v >> 8)) >> 8, exact below 65280
  always_comb begin
    mixed[31:24] = alpha_r;
    for (int i = 0; i < 3; i++) begin
      rnd[i]            = acc_r[i] + 16'd1 + (acc_r[i] >> 8);
      mixed[8*i +: 8]   = rnd[i][15:8];
    end
  end

  // an all-zero color counts as absent
  assign mix_c = old_zero_r ? new_r : (new_zero_r ? old_r : mixed);

endmodule
